### rtl/core/aes_ctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_pkg
// Shared constants, types and AES helper functions for the CTR unit.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

    localparam int NumRounds = 10;
    localparam int AddrWidth = 5;

    localparam logic [AddrWidth-1:0] RegKeyHigh = 5'd0;
    localparam logic [AddrWidth-1:0] RegKeyLow  = 5'd8;
    localparam logic [AddrWidth-1:0] RegNonce   = 5'd16;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] rkey;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } aes_ctr_lane_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block sits in bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

endpackage

### rtl/core/aes_ctr_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_round_cell
// One AES round and one key expansion step, registered at the output.
// ----------------------------------------------------------------------------
module aes_ctr_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  aes_ctr_pkg::aes_ctr_lane_t in_lane,
    output logic                       out_valid,
    output aes_ctr_pkg::aes_ctr_lane_t out_lane
);
    import aes_ctr_pkg::*;

    logic [127:0] rk_next;
    logic [127:0] sb;
    logic [127:0] mc;
    logic [127:0] st_next;
    logic         valid_reg;
    aes_ctr_lane_t lane_reg;

    always_comb
    begin
        logic [7:0] k [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
        begin
            k[i] = get_byte(in_lane.rkey, i);
        end
        t[0] = k[0] ^ sbox(k[13]) ^ rcon(ROUND);
        t[1] = k[1] ^ sbox(k[14]);
        t[2] = k[2] ^ sbox(k[15]);
        t[3] = k[3] ^ sbox(k[12]);
        for (int i = 4; i < 16; i++)
        begin
            t[i] = k[i] ^ t[i-4];
        end
        for (int i = 0; i < 16; i++)
        begin
            rk_next[127 - 8*i -: 8] = t[i];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[127 - 8*(c*4+r) -: 8] = sbox(get_byte(in_lane.state, ((c + r) % 4)*4 + r));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(sb, c*4);
            a1 = get_byte(sb, c*4+1);
            a2 = get_byte(sb, c*4+2);
            a3 = get_byte(sb, c*4+3);
            mc[127 - 8*(c*4) -: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[127 - 8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            mc[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            mc[127 - 8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        st_next = ((ROUND == 4'(NumRounds)) ? sb : mc) ^ rk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg.state  <= st_next;
            lane_reg.rkey   <= rk_next;
            lane_reg.data   <= in_lane.data;
            lane_reg.nbytes <= in_lane.nbytes;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

### rtl/core/aes128_ctr_crypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_crypt_unit
// AES-128 counter mode: a chain of ten round cells, one block per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
// Channel  Role     Fields
// s_axis   input    tdata = data_high[63:0], data_low[127:64], valid_bytes[132:128]
//                   tuser = first_block
// m_axis   output   tdata = result_high[63:0], result_low[127:64], result_bytes[132:128]
// apb      config   key_high @0x00, key_low @0x08, nonce_value @0x10
//
// One item enters per cycle unless m_axis stalls; each result passes through
// the ten round cells and then the output register. The whole chain advances
// only when the output register is free or being taken, so a stall on m_axis
// holds every item in place. Reset clears counter, key, nonce and valid bits.
// ----------------------------------------------------------------------------
module aes128_ctr_crypt_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aes_ctr_pkg::AddrWidth-1:0] paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [135:0]                     s_axis_tdata,  // data_high, data_low, valid_bytes
    input  logic                             s_axis_tuser,  // first_block
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [135:0]                     m_axis_tdata   // result_high, result_low, result_bytes
);
    import aes_ctr_pkg::*;

    logic [63:0]   key_high_reg, key_low_reg, nonce_reg, ctr_reg;
    logic          adv;
    logic          v [NumRounds+1];
    aes_ctr_lane_t l [NumRounds+1];
    logic          out_valid_reg;
    logic [135:0]  out_data_reg;
    logic [63:0]   ctr_use;
    logic [127:0]  res;
    logic          wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            nonce_reg    <= '0;
        end
        else if (wr)
        begin
            if (paddr == RegKeyHigh) key_high_reg <= pwdata;
            if (paddr == RegKeyLow)  key_low_reg  <= pwdata;
            if (paddr == RegNonce)   nonce_reg    <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == RegKeyHigh) prdata = key_high_reg;
        if (paddr == RegKeyLow)  prdata = key_low_reg;
        if (paddr == RegNonce)   prdata = nonce_reg;
    end

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign ctr_use = s_axis_tuser ? 64'd0 : ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            ctr_reg <= ctr_use + 64'd1;
        end
    end

    // Entry lane: initial AddRoundKey done here with the raw key.
    assign v[0]        = s_axis_tvalid;
    assign l[0].state  = {nonce_reg, ctr_use} ^ {key_high_reg, key_low_reg};
    assign l[0].rkey   = {key_high_reg, key_low_reg};
    assign l[0].data   = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign l[0].nbytes = s_axis_tdata[132:128];

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_cells
        aes_ctr_round_cell #(.ROUND(4'(g + 1))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v[g]),
            .in_lane   (l[g]),
            .out_valid (v[g+1]),
            .out_lane  (l[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            res[127 - 8*i -: 8] = (5'(i) < l[NumRounds].nbytes)
                ? (get_byte(l[NumRounds].data, i) ^ get_byte(l[NumRounds].state, i))
                : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v[NumRounds];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {3'b000, l[NumRounds].nbytes, res[63:0], res[127:64]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> ctr_reg == 64'd1)
        else $error("counter did not restart");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

### tb/sv/aes128_ctr_crypt_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_crypt_unit_tb
// Self-checking bench for the AES-128 counter mode unit. Items go in on the
// s_axis side, with random gaps in some phases. Each accepted item is run
// through a behavioural AES-128 in the bench, which gives the expected
// keystream XOR. Results taken from m_axis are checked field by field, in
// order. Key and nonce change between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
module aes128_ctr_crypt_unit_tb;

    import aes_ctr_pkg::*;

    typedef struct {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  nbytes;
        logic        restart;
    } block_item_t;

    typedef struct {
        logic [63:0] text_high;
        logic [63:0] text_low;
        logic [4:0]  nbytes;
    } crypt_result_t;

    localparam int          WatchdogLimit = 4000;
    localparam int          LongHold      = 400;
    localparam logic [4:0]  RegUnused     = 5'd24;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [63:0]          pwdata = '0;
    logic [63:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // valid_bytes[132:128], data_low[127:64], data_high[63:0]
    logic [135:0]         s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;  // first_block
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // result_bytes[132:128], result_low[127:64], result_high[63:0]
    logic [135:0]         m_axis_tdata;

    aes128_ctr_crypt_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    logic [7:0] sub_tbl [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    // Bench copy of the registers and the block counter.
    logic [63:0] key_hi_q = '0;
    logic [63:0] key_lo_q = '0;
    logic [63:0] nonce_q = '0;
    logic [63:0] blk_count = '0;

    block_item_t   pending_blocks[$];
    crypt_result_t expected_text[$];
    int            send_gap_pct = 0;
    int            recv_gap_pct = 0;
    int            blocks_taken = 0;
    int            errors = 0;
    int            quiet_cycles = 0;
    bit            hold_done = 1'b0;
    int            hold_left = 0;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] blk);
        logic [7:0]   rk [16];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rc;
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            st[i] = blk[127-8*i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    sh[c*4+row] = sub_tbl[st[((c + row) & 3)*4 + row]];
            for (int c = 0; c < 4; c++)
            begin
                a0 = sh[c*4]; a1 = sh[c*4+1]; a2 = sh[c*4+2]; a3 = sh[c*4+3];
                if (r < 10)
                begin
                    st[c*4]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    st[c*4+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    st[c*4+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    st[c*4+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
                else
                begin
                    st[c*4] = a0; st[c*4+1] = a1; st[c*4+2] = a2; st[c*4+3] = a3;
                end
            end
            a0 = rk[13]; a1 = rk[14]; a2 = rk[15]; a3 = rk[12];
            rk[0] = rk[0] ^ sub_tbl[a0] ^ rc;
            rk[1] = rk[1] ^ sub_tbl[a1];
            rk[2] = rk[2] ^ sub_tbl[a2];
            rk[3] = rk[3] ^ sub_tbl[a3];
            for (int i = 4; i < 16; i++)
                rk[i] = rk[i] ^ rk[i-4];
            rc = gf_double(rc);
            for (int i = 0; i < 16; i++)
                st[i] = st[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    task automatic predict_block(input block_item_t it);
        logic [127:0]  stream;
        logic [127:0]  msg;
        logic [127:0]  txt;
        int            count;
        crypt_result_t exp;
        if (it.restart)
            blk_count = '0;
        count = (it.nbytes > 16) ? 16 : it.nbytes;
        stream = aes_encrypt({key_hi_q, key_lo_q}, {nonce_q, blk_count});
        msg = {it.data_high, it.data_low};
        txt = '0;
        for (int i = 0; i < 16; i++)
            if (i < count)
                txt[127-8*i -: 8] = msg[127-8*i -: 8] ^ stream[127-8*i -: 8];
        exp.text_high = txt[127:64];
        exp.text_low = txt[63:0];
        exp.nbytes = it.nbytes;
        expected_text = {expected_text, exp};
        blk_count = blk_count + 64'd1;
    endtask

    // Driver: the item on the bus stays until accepted.
    block_item_t on_bus;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_block(on_bus);
                blocks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_blocks.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    on_bus = pending_blocks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, on_bus.nbytes, on_bus.data_low, on_bus.data_high};
                    s_axis_tuser <= on_bus.restart;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver, with one long hold-off so the round chain fills and stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && blocks_taken >= 300)
        begin
            hold_done = 1'b1;
            hold_left = LongHold;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            crypt_result_t exp;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp = expected_text.pop_front();
                if (m_axis_tdata[63:0] !== exp.text_high)
                begin
                    $display("%0t: result_high expected %h actual %h",
                             $time, exp.text_high, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== exp.text_low)
                begin
                    $display("%0t: result_low expected %h actual %h",
                             $time, exp.text_low, m_axis_tdata[127:64]);
                    errors++;
                end
                if (m_axis_tdata[132:128] !== exp.nbytes)
                begin
                    $display("%0t: result_bytes expected %0d actual %0d",
                             $time, exp.nbytes, m_axis_tdata[132:128]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic reg_write(input logic [AddrWidth-1:0] addr, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == RegKeyHigh)
            key_hi_q = value;
        else if (addr == RegKeyLow)
            key_lo_q = value;
        else if (addr == RegNonce)
            nonce_q = value;
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() > 0 || s_axis_tvalid || expected_text.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] nb, input logic first);
        block_item_t it;
        it.data_high = hi;
        it.data_low = lo;
        it.nbytes = nb;
        it.restart = first;
        pending_blocks = {pending_blocks, it};
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly whole messages; some noise with odd counts and stray restarts.
    task automatic add_random_traffic(input int n);
        int len;
        while (n > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_block(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom));
                n--;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int b = 0; b < len; b++)
                    add_block(rand64(), rand64(),
                              (b == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16, b == 0);
                n -= len;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values first: all-zero key and nonce.
        add_block('0, '0, 5'd16, 1'b1);
        add_block('1, '1, 5'd16, 1'b0);
        add_block('1, '1, 5'd0, 1'b0);
        add_block('1, '1, 5'd1, 1'b0);
        add_block('1, '1, 5'd15, 1'b0);
        add_block('1, '1, 5'd17, 1'b0);
        add_block('1, '1, 5'd31, 1'b1);
        add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1'b0);
        add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 1'b1);
        wait_drained();

        reg_write(RegKeyHigh, '1);
        reg_write(RegKeyLow, '1);
        reg_write(RegNonce, '1);
        reg_write(RegUnused, 64'h5a5a5a5a5a5a5a5a);
        add_block('0, '0, 5'd16, 1'b1);
        add_block('1, '0, 5'd16, 1'b0);
        add_block('0, '1, 5'd16, 1'b0);
        add_block(rand64(), rand64(), 5'd0, 1'b0);
        add_block(rand64(), rand64(), 5'd16, 1'b0);
        add_block(rand64(), rand64(), 5'd31, 1'b1);
        wait_drained();

        // Known test vector key and a nonce with only the top and bottom bits set.
        reg_write(RegKeyHigh, 64'h2b7e151628aed2a6);
        reg_write(RegKeyLow, 64'habf7158809cf4f3c);
        reg_write(RegNonce, 64'h8000000000000001);
        add_block(rand64(), rand64(), 5'd16, 1'b1);
        add_block(rand64(), rand64(), 5'd16, 1'b0);
        add_block(rand64(), rand64(), 5'd5, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_gap_pct = (phase < 2) ? 15 : (phase < 4) ? 47 : 0;
            recv_gap_pct = (phase < 2) ? 47 : (phase < 4) ? 15 : 0;
            if (phase == 5)
            begin
                reg_write(RegKeyHigh, '0);
                reg_write(RegKeyLow, '0);
                reg_write(RegNonce, '0);
            end
            else
            begin
                reg_write(RegKeyHigh, rand64());
                reg_write(RegKeyLow, rand64());
                reg_write(RegNonce, rand64());
            end
            add_random_traffic(165);
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
